/* hdl/ffsa_pkg.sv */
// Shared types, constants and codes for the first-fit segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

  localparam int unsigned MAX_SEGMENTS = 64;
  localparam int unsigned IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned GRAN_W       = 28;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_HEAP_BASE     = 1'b0,
    REG_HEAP_GRANULES = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_ARD,
    S_ACHK,
    S_DRD,
    S_DWR,
    S_FPREP,
    S_FRD,
    S_FCHK,
    S_FDEC,
    S_IRD,
    S_IWR,
    S_OUT
  } state_e;

  // One free segment: header granule and payload granules.
  typedef struct packed {
    logic [GRAN_W-1:0] start;
    logic [GRAN_W-1:0] size;
  } entry_t;

  // Access request from the sequencer to the segment table.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

endpackage
`default_nettype wire

/* hdl/ffsa_table.sv */
// Segment table memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_table
  import ffsa_pkg::*;
(
  input  wire      clk_i,
  input  tbl_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [MAX_SEGMENTS];
  entry_t rdata_q;

  // Write and read happen at the same edge; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* hdl/first_fit_segment_allocator_unit.sv */
// First-fit segment allocator: top level with the sequencer and datapath.
//
// Input channel (in_valid_i / in_ready_o) takes one beat per request:
// op_i selects allocate or free. Output channel (out_valid_o /
// out_ready_i) returns one beat per request with status, grant address
// and granted granules. in_ready_o is high only while the sequencer is
// idle, so one request is worked on at a time.
// The segment table sits in a single-port-read memory; every table step
// is a read followed by a compare or a write, so an allocate steps through
// each entry scanned, and a free through each entry below the insertion
// point and each entry moved by an insert or a removal.
// After reset the table is empty; the first request of either kind first
// lays down one segment covering the configured heap. The configuration
// port is sampled at that moment only.
// The result stays in the output register while out_ready_i is low; the
// sequencer then waits in its final state before taking the next beat.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator_unit
  import ffsa_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [0:0]         cfg_addr_i,
  input  wire  [GRAN_W-1:0]  cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [0:0]         op_i,
  input  wire  [31:0]        request_bytes_i,
  input  wire  [31:0]        block_address_i,
  input  wire  [GRAN_W-1:0]  block_granules_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [1:0]         status_o,
  output logic [31:0]        grant_address_o,
  output logic [GRAN_W-1:0]  grant_granules_o
);

  localparam logic [GRAN_W+1:0] SPACE = 30'(1) << GRAN_W;

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d, idx_q, idx_d, pos_q, pos_d;
  logic ready_q, ready_d;
  logic [GRAN_W-1:0] base_q, hgran_q;
  logic op_q, op_d;
  logic [GRAN_W:0] g_q, g_d, top_q, top_d, prev_top_q, prev_top_d;
  logic [31:0] addr_q, addr_d;
  logic [GRAN_W-1:0] gran_q, gran_d, c_q, c_d;
  logic [GRAN_W-1:0] prev_start_q, prev_start_d, next_start_q, next_start_d;
  logic [GRAN_W-1:0] next_size_q, next_size_d;
  logic [1:0] res_status_q, res_status_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic [GRAN_W-1:0] res_gran_q, res_gran_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [31:0] gaddr_q, gaddr_d;
  logic [GRAN_W-1:0] ggran_q, ggran_d;

  tbl_req_t req;
  entry_t rdata;

  logic [GRAN_W+1:0] init_sum, free_sum;
  logic [GRAN_W-1:0] c_calc, hdr_inc;
  logic mprev, mnext;

  ffsa_table u_table (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      hgran_q <= GRAN_W'(65536);
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_HEAP_BASE:     base_q  <= cfg_data_i;
        REG_HEAP_GRANULES: hgran_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    g_q          <= g_d;
    addr_q       <= addr_d;
    gran_q       <= gran_d;
    c_q          <= c_d;
    top_q        <= top_d;
    prev_start_q <= prev_start_d;
    prev_top_q   <= prev_top_d;
    next_start_q <= next_start_d;
    next_size_q  <= next_size_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_gran_q   <= res_gran_d;
    status_q     <= status_d;
    gaddr_q      <= gaddr_d;
    ggran_q      <= ggran_d;
  end

  assign init_sum = {2'b00, base_q} + {2'b00, hgran_q} + 30'd1;
  assign c_calc   = addr_q[31:4] - GRAN_W'(1);
  assign free_sum = {2'b00, c_calc} + {2'b00, gran_q} + 30'd1;
  assign hdr_inc  = rdata.start + GRAN_W'(1);
  assign mprev    = (idx_q != '0) && (prev_top_q == {1'b0, c_q});
  assign mnext    = (idx_q < count_q) && (top_q == {1'b0, next_start_q});

  // Next state, table requests and datapath updates.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ready_d      = ready_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    op_d         = op_q;
    g_d          = g_q;
    addr_d       = addr_q;
    gran_d       = gran_q;
    c_d          = c_q;
    top_d        = top_q;
    prev_start_d = prev_start_q;
    prev_top_d   = prev_top_q;
    next_start_d = next_start_q;
    next_size_d  = next_size_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_gran_d   = res_gran_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    gaddr_d      = gaddr_q;
    ggran_d      = ggran_q;
    req          = '0;
    in_ready_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d         = op_i;
          g_d          = 29'(({1'b0, request_bytes_i} + 33'd15) >> 4);
          addr_d       = block_address_i;
          gran_d       = block_granules_i;
          res_status_d = ST_OK;
          res_addr_d   = '0;
          res_gran_d   = '0;
          idx_d        = '0;
          if (!ready_q) begin
            state_d = S_INIT;
          end else if (op_e'(op_i) == OP_FREE) begin
            state_d = S_FPREP;
          end else begin
            state_d = S_ARD;
          end
        end
      end

      // Lay down the single initial segment, clipped to the granule space.
      S_INIT: begin
        req.we          = 1'b1;
        req.waddr       = '0;
        req.wdata.start = base_q;
        req.wdata.size  = (init_sum > SPACE) ? ~base_q : hgran_q;
        count_d         = CNT_W'(1);
        ready_d         = 1'b1;
        state_d         = (op_e'(op_q) == OP_FREE) ? S_FPREP : S_ARD;
      end

      // Allocate: scan for the lowest segment that fits.
      S_ARD: begin
        if (idx_q == count_q) begin
          res_status_d = ST_NO_FIT;
          state_d      = S_OUT;
        end else begin
          req.raddr = idx_q[IDX_W-1:0];
          state_d   = S_ACHK;
        end
      end

      S_ACHK: begin
        if (g_q <= {1'b0, rdata.size}) begin
          res_addr_d = {hdr_inc, 4'b0000};
          if ({1'b0, rdata.size} <= g_q + 29'd1) begin
            res_gran_d = rdata.size;
            state_d    = S_DRD;
          end else begin
            res_gran_d      = g_q[GRAN_W-1:0];
            req.we          = 1'b1;
            req.waddr       = idx_q[IDX_W-1:0];
            req.wdata.start = hdr_inc + g_q[GRAN_W-1:0];
            req.wdata.size  = rdata.size - g_q[GRAN_W-1:0] - GRAN_W'(1);
            state_d         = S_OUT;
          end
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_ARD;
        end
      end

      // Remove entry idx by moving the entries above it down one place.
      S_DRD: begin
        if (idx_q + CNT_W'(1) < count_q) begin
          req.raddr = IDX_W'(idx_q + CNT_W'(1));
          state_d   = S_DWR;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_OUT;
        end
      end

      S_DWR: begin
        req.we    = 1'b1;
        req.waddr = idx_q[IDX_W-1:0];
        req.wdata = rdata;
        idx_d     = idx_q + CNT_W'(1);
        state_d   = S_DRD;
      end

      // Free: header index, clipped size and top of the freed block.
      S_FPREP: begin
        if (addr_q[31:4] == '0) begin
          state_d = S_OUT;
        end else begin
          c_d = c_calc;
          if (free_sum > SPACE) begin
            gran_d = ~c_calc;
            top_d  = SPACE[GRAN_W:0];
          end else begin
            top_d = free_sum[GRAN_W:0];
          end
          state_d = S_FRD;
        end
      end

      // Free: find the first entry whose header is not below the block.
      S_FRD: begin
        if (idx_q == count_q) begin
          state_d = S_FDEC;
        end else begin
          req.raddr = idx_q[IDX_W-1:0];
          state_d   = S_FCHK;
        end
      end

      S_FCHK: begin
        if (rdata.start < c_q) begin
          prev_start_d = rdata.start;
          prev_top_d   = {1'b0, rdata.start} + {1'b0, rdata.size} + 29'd1;
          idx_d        = idx_q + CNT_W'(1);
          state_d      = S_FRD;
        end else begin
          next_start_d = rdata.start;
          next_size_d  = rdata.size;
          state_d      = S_FDEC;
        end
      end

      // Free: merge with neighbours, open a new entry, or report a full table.
      S_FDEC: begin
        priority if (mprev && mnext) begin
          req.we          = 1'b1;
          req.waddr       = IDX_W'(idx_q - CNT_W'(1));
          req.wdata.start = prev_start_q;
          req.wdata.size  = next_start_q + next_size_q - prev_start_q;
          state_d         = S_DRD;
        end else if (mprev) begin
          req.we          = 1'b1;
          req.waddr       = IDX_W'(idx_q - CNT_W'(1));
          req.wdata.start = prev_start_q;
          req.wdata.size  = c_q + gran_q - prev_start_q;
          state_d         = S_OUT;
        end else if (mnext) begin
          req.we          = 1'b1;
          req.waddr       = idx_q[IDX_W-1:0];
          req.wdata.start = c_q;
          req.wdata.size  = next_start_q + next_size_q - c_q;
          state_d         = S_OUT;
        end else if (count_q >= CNT_W'(MAX_SEGMENTS)) begin
          res_status_d = ST_FULL;
          state_d      = S_OUT;
        end else begin
          pos_d   = idx_q;
          idx_d   = count_q;
          state_d = S_IRD;
        end
      end

      // Insert at pos by moving the entries from pos upwards one place.
      S_IRD: begin
        if (idx_q > pos_q) begin
          req.raddr = IDX_W'(idx_q - CNT_W'(1));
          state_d   = S_IWR;
        end else begin
          req.we          = 1'b1;
          req.waddr       = pos_q[IDX_W-1:0];
          req.wdata.start = c_q;
          req.wdata.size  = gran_q;
          count_d         = count_q + CNT_W'(1);
          state_d         = S_OUT;
        end
      end

      S_IWR: begin
        req.we    = 1'b1;
        req.waddr = idx_q[IDX_W-1:0];
        req.wdata = rdata;
        idx_d     = idx_q - CNT_W'(1);
        state_d   = S_IRD;
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          gaddr_d     = res_addr_q;
          ggran_d     = res_gran_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign grant_address_o  = gaddr_q;
  assign grant_granules_o = ggran_q;

  // The table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count above capacity");

  // Once the heap is set up it stays set up.
  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |=> ready_q)
    else $error("heap ready flag dropped");

  // The count moves by at most one entry per cycle.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1)))
    else $error("segment count jumped");

  // An accepted beat always starts work.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted beat left sequencer idle");

endmodule
`default_nettype wire

/* test/first_fit_segment_allocator_unit_test.sv */
// Self-checking testbench for the first-fit segment allocator unit.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator_unit_test;
  import ffsa_pkg::*;

  localparam longint unsigned GRAN_SPACE = 64'h1000_0000;

  // One request as offered on the input channel.
  typedef struct {
    op_e               op;
    logic [31:0]       bytes;
    logic [31:0]       addr;
    logic [GRAN_W-1:0] gran;
  } request_t;

  // One answer as returned on the output channel.
  typedef struct {
    status_e           st;
    logic [31:0]       addr;
    logic [GRAN_W-1:0] gran;
  } grant_t;

  // Keeps its own copy of the free segment table, predicts each answer and
  // remembers the blocks that are currently handed out.
  class alloc_scoreboard;
    logic [GRAN_W-1:0] seg_start[MAX_SEGMENTS];
    logic [GRAN_W-1:0] seg_size[MAX_SEGMENTS];
    int unsigned       seg_count = 0;
    bit                heap_set = 0;
    logic [GRAN_W-1:0] base_reg = '0;
    logic [GRAN_W-1:0] size_reg = 28'd65536;
    grant_t            grant_q[$];
    grant_t            live_q[$];
    int                errors = 0;

    function void write_reg(reg_e r, logic [GRAN_W-1:0] v);
      if (r == REG_HEAP_BASE) base_reg = v;
      else size_reg = v;
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    function logic [GRAN_W-1:0] first_size();
      return (seg_count > 0) ? seg_size[0] : '0;
    endfunction

    function void drop_entry(int unsigned i);
      for (int unsigned k = i; k + 1 < seg_count; k++) begin
        seg_start[k] = seg_start[k+1];
        seg_size[k]  = seg_size[k+1];
      end
      seg_count--;
    endfunction

    function longint unsigned seg_end(int unsigned i);
      return longint'(seg_start[i]) + 1 + seg_size[i];
    endfunction

    function void note_request(request_t r);
      grant_t          g;
      longint unsigned want, sz, c, top, gr, bsz;
      int unsigned     pos;
      bit              mprev, mnext;
      // The first beat after reset lays down the whole heap as one segment.
      if (!heap_set) begin
        bsz = size_reg;
        if (longint'(base_reg) + 1 + bsz > GRAN_SPACE) bsz = GRAN_SPACE - 1 - base_reg;
        seg_start[0] = base_reg;
        seg_size[0]  = bsz[GRAN_W-1:0];
        seg_count    = 1;
        heap_set     = 1;
      end
      g = '{st: ST_OK, addr: '0, gran: '0};
      if (r.op == OP_ALLOC) begin
        want = (longint'(r.bytes) + 15) >> 4;
        g.st = ST_NO_FIT;
        for (int unsigned i = 0; i < seg_count; i++) begin
          sz = seg_size[i];
          if (want <= sz) begin
            g.st   = ST_OK;
            c      = (longint'(seg_start[i]) + 1) << 4;
            g.addr = c[31:0];
            if (sz <= want + 1) begin
              g.gran = sz[GRAN_W-1:0];
              drop_entry(i);
            end else begin
              g.gran      = want[GRAN_W-1:0];
              top         = longint'(seg_start[i]) + 1 + want;
              seg_start[i] = top[GRAN_W-1:0];
              sz          = sz - want - 1;
              seg_size[i] = sz[GRAN_W-1:0];
            end
            live_q.push_back(g);
            break;
          end
        end
      end else if (r.addr >= 16) begin
        // A free goes back in address order and merges with its neighbours.
        c  = (longint'(r.addr) >> 4) - 1;
        gr = r.gran;
        if (c + 1 + gr > GRAN_SPACE) gr = GRAN_SPACE - 1 - c;
        top = c + 1 + gr;
        pos = 0;
        while (pos < seg_count && seg_start[pos] < c) pos++;
        mprev = pos > 0 && seg_end(pos - 1) == c;
        mnext = pos < seg_count && top == seg_start[pos];
        if (mprev && mnext) begin
          sz = seg_end(pos) - seg_start[pos-1] - 1;
          seg_size[pos-1] = sz[GRAN_W-1:0];
          drop_entry(pos);
        end else if (mprev) begin
          sz = top - seg_start[pos-1] - 1;
          seg_size[pos-1] = sz[GRAN_W-1:0];
        end else if (mnext) begin
          sz = seg_end(pos) - c - 1;
          seg_size[pos]  = sz[GRAN_W-1:0];
          seg_start[pos] = c[GRAN_W-1:0];
        end else if (seg_count >= MAX_SEGMENTS) begin
          g.st = ST_FULL;
        end else begin
          for (int unsigned k = seg_count; k > pos; k--) begin
            seg_start[k] = seg_start[k-1];
            seg_size[k]  = seg_size[k-1];
          end
          seg_start[pos] = c[GRAN_W-1:0];
          seg_size[pos]  = gr[GRAN_W-1:0];
          seg_count++;
        end
      end
      grant_q.push_back(g);
    endfunction

    function void check_result(grant_t got);
      grant_t w;
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d", $time, got.st);
        errors++;
        return;
      end
      w = grant_q.pop_front();
      if (got.st !== w.st) begin
        $display("%0t: status expected %0d actual %0d", $time, w.st, got.st);
        errors++;
      end
      if (got.addr !== w.addr) begin
        $display("%0t: grant_address expected %h actual %h", $time, w.addr, got.addr);
        errors++;
      end
      if (got.gran !== w.gran) begin
        $display("%0t: grant_granules expected %h actual %h", $time, w.gran, got.gran);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [0:0]        cfg_addr_i;
  logic [GRAN_W-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [0:0]        op_i;
  logic [31:0]       request_bytes_i;
  logic [31:0]       block_address_i;
  logic [GRAN_W-1:0] block_granules_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic [31:0]       grant_address_o;
  logic [GRAN_W-1:0] grant_granules_o;

  alloc_scoreboard sb = new();
  int              results_seen = 0;
  int              sent = 0;

  first_fit_segment_allocator_unit i_dut (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then long; none in burst stretches.
  function automatic int pick_gap(int count);
    int r;
    r = $urandom_range(99);
    if ((count / 100) % 4 == 3) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic write_reg(reg_e r, logic [GRAN_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(r, v);
  endtask

  // Offer one beat after an optional gap and wait until it is taken.
  task automatic send(request_t r);
    int gap;
    gap = pick_gap(sent);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= r.op;
    request_bytes_i  <= r.bytes;
    block_address_i  <= r.addr;
    block_granules_i <= r.gran;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    sent++;
  endtask

  task automatic alloc(logic [31:0] bytes);
    send('{op: OP_ALLOC, bytes: bytes, addr: $urandom, gran: 28'($urandom)});
  endtask

  task automatic free(logic [31:0] addr, logic [GRAN_W-1:0] gran);
    send('{op: OP_FREE, bytes: $urandom, addr: addr, gran: gran});
  endtask

  // Hand back a randomly chosen live block, sometimes with a ragged address.
  task automatic free_live();
    int     j;
    grant_t b;
    if (sb.live_q.size() == 0) return;
    j = $urandom_range(sb.live_q.size() - 1);
    b = sb.live_q[j];
    sb.live_q.delete(j);
    free(b.addr | (($urandom_range(9) == 0) ? $urandom_range(15) : 0), b.gran);
  endtask

  // Stop offering, let every answer arrive and the sequencer settle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    int p;
    repeat (n) begin
      p = $urandom_range(99);
      if (p < 45) alloc($urandom_range(9) == 0 ? $urandom_range(20000) : $urandom_range(400));
      else if (p < 85 && sb.live_q.size() > 0) free_live();
      else if (p < 90) alloc($urandom);
      else if (p < 95) free($urandom, 28'($urandom));
      else free({4'hF, 28'($urandom)}, 28'($urandom_range(300)));
    end
  endtask

  // Receiver: random stalls, one long hold-off while the sender keeps going.
  initial begin
    bit held;
    int gap;
    held = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      gap = pick_gap(results_seen + 50);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{st: status_e'(status_o), addr: grant_address_o,
                        gran: grant_granules_o});
      results_seen++;
    end
  end

  // Overall time limit.
  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  // Stimulus.
  initial begin
    grant_t frag_q[$];
    int     n0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_addr_i       = REG_HEAP_BASE;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    op_i             = OP_ALLOC;
    request_bytes_i  = '0;
    block_address_i  = '0;
    block_granules_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Heap near the top of granule space and too large, so it gets cut.
    write_reg(REG_HEAP_BASE, 28'h0FFE_FFF0);
    write_reg(REG_HEAP_GRANULES, 28'h0FFF_FFFF);

    // Directed: extremes, ignored frees, cut frees, empty table.
    alloc(32'd0);
    alloc(32'hFFFF_FFFF);
    alloc(32'd1);
    alloc(32'd17);
    free(32'd0, 28'd5);
    free(32'd15, 28'h0FFF_FFFF);
    free(32'hFFFF_FFFF, 28'h0FFF_FFFF);
    free_live();
    free_live();
    alloc(32'd100);
    alloc({sb.first_size(), 4'h0});
    free_live();
    alloc(32'd48);
    alloc(32'hFFFF_FFF0);
    free_live();
    free_live();
    free_live();
    settle();

    // Registers written after setup must have no effect.
    write_reg(REG_HEAP_BASE, '0);
    write_reg(REG_HEAP_GRANULES, 28'h0FFF_FFFF);
    random_phase(320);
    settle();

    write_reg(REG_HEAP_BASE, 28'h0FFF_FFFF);
    write_reg(REG_HEAP_GRANULES, '0);

    // Fragment the heap with every other block returned to fill the table.
    n0 = sb.live_q.size();
    repeat (140) alloc($urandom_range(16));
    frag_q = sb.live_q[n0:$];
    sb.live_q = sb.live_q[0:n0-1];
    foreach (frag_q[j]) begin
      if (j % 2 == 0) free(frag_q[j].addr, frag_q[j].gran);
      else sb.live_q.push_back(frag_q[j]);
    end
    settle();

    write_reg(REG_HEAP_BASE, 28'($urandom));
    write_reg(REG_HEAP_GRANULES, 28'($urandom));
    random_phase(300);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
hdl/ffsa_pkg.sv
hdl/ffsa_table.sv
hdl/first_fit_segment_allocator_unit.sv
test/first_fit_segment_allocator_unit_test.sv
